@@ sv/cts_pkg.sv @@
// Package with shared types and constants of the CPU time split scaler.
`default_nettype none
package cts_pkg;
	localparam int unsigned DW = 64;
	localparam int unsigned RW = 11;
	localparam logic [DW-1:0] NS_PER_SEC = 64'd1000000000;
	localparam logic [DW-1:0] NS_X9 = 64'd9000000000;
	localparam logic [DW-1:0] NS_PER_512 = 64'd1953125;
	localparam logic [RW-1:0] RATE_RESET = 11'd250;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_WRATE  = 12'b000000000010,
		S_WDIVR  = 12'b000000000100,
		S_WTICKS = 12'b000000001000,
		S_CMP    = 12'b000000010000,
		S_NORM   = 12'b000000100000,
		S_MUL    = 12'b000001000000,
		S_SHARE  = 12'b000010000000,
		S_WSHARE = 12'b000100000000,
		S_FIN    = 12'b001000000000,
		S_OUT    = 12'b010000000000,
		S_START  = 12'b100000000000
	} state_t;
endpackage
`default_nettype wire

@@ sv/cts_sample_if.sv @@
// Input channel carrying one task accounting sample.
`default_nettype none
interface cts_sample_if;
	logic        valid;
	logic        ready;
	logic [63:0] user_ticks;
	logic [63:0] system_ticks;
	logic [63:0] runtime_ns;
	logic [63:0] prev_user_time;
	logic [63:0] prev_system_time;
	modport source(output valid, user_ticks, system_ticks, runtime_ns, prev_user_time,
		prev_system_time, input ready);
	modport sink(input valid, user_ticks, system_ticks, runtime_ns, prev_user_time,
		prev_system_time, output ready);
endinterface
`default_nettype wire

@@ sv/cts_result_if.sv @@
// Output channel carrying the adjusted user and system times.
`default_nettype none
interface cts_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] user_time;
	logic [63:0] system_time;
	modport source(output valid, user_time, system_time, input ready);
	modport sink(input valid, user_time, system_time, output ready);
endinterface
`default_nettype wire

@@ sv/cts_div.sv @@
// Shared 64-bit restoring divider, one quotient bit per cycle.
`default_nettype none
module cts_div import cts_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [DW-1:0]      quotient,
	output logic [DW-1:0]      remainder
);
	logic [DW-1:0] r_q, q_q, d_q;
	logic [5:0]    cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   trial, diff;
	logic          ge;

	always_comb begin
		trial = {r_q, q_q[DW-1]};
		diff  = trial - {1'b0, d_q};
		ge    = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd63) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			q_q <= dividend;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			q_q <= {q_q[DW-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = q_q;
	assign remainder = r_q;
endmodule
`default_nettype wire

@@ sv/cpu_time_split_scaler.sv @@
// Top level of the CPU time split scaler: sequencer around the shared divider.
`default_nettype none
// The block takes no new item until its result is delivered. The time an item
// takes is set by the shared divider, used two or three times for the tick
// conversion and at most once for the proportional split, plus the operand
// normalization loop that runs one shift step per cycle. When the previous
// times already cover the runtime, the split is skipped and only the tick
// conversion is paid for. The user must write the rate register only between
// items for a write to take effect on the next item; the block does not enforce it.
module cpu_time_split_scaler import cts_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [RW-1:0] cfg_wdata,
	cts_sample_if.sink         sample,
	cts_result_if.source       result
);
	state_t        state_q;
	logic [RW-1:0] rate_q;
	logic [DW-1:0] ut_q, st_q, ns_q, pu_q, ps_q, psum_q, rt_q;
	logic [DW-1:0] part_q, whole_q, total_q, prod_q, shs_q, shu_q;
	logic [DW-1:0] dvd_q, dvs_q;
	logic          dstart_q;
	logic          div_done;
	logic [DW-1:0] div_quo, div_rem;
	logic [RW-1:0] hz;
	logic [DW-1:0] p_sw, w_sw, scaled;
	logic          norm_end;

	cts_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart_q), .dividend(dvd_q),
		.divisor(dvs_q), .done(div_done), .quotient(div_quo), .remainder(div_rem)
	);

	always_comb begin
		hz     = (rate_q == '0) ? RW'(1) : rate_q;
		scaled = ns_q * {{(DW-RW){1'b0}}, hz};
		p_sw   = (part_q > whole_q) ? whole_q : part_q;
		w_sw   = (part_q > whole_q) ? part_q : whole_q;
		norm_end = (total_q[63:32] == '0) && (w_sw[63:32] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (cfg_we) begin
			rate_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			dstart_q <= 1'b0;
		end else begin
			dstart_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (sample.valid) begin
					state_q <= S_START;
				end
				S_START: begin
					dstart_q <= 1'b1;
					state_q  <= S_WRATE;
				end
				S_WRATE: if (div_done) begin
					dstart_q <= 1'b1;
					if (div_rem == '0 || hz[8:0] == '0) begin
						state_q <= S_WTICKS;
					end else begin
						state_q <= S_WDIVR;
					end
				end
				S_WDIVR: if (div_done) begin
					dstart_q <= 1'b1;
					state_q  <= S_WTICKS;
				end
				S_WTICKS: if (div_done) begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (psum_q >= rt_q) begin
						state_q <= S_OUT;
					end else if (ut_q == '0 || st_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_NORM;
					end
				end
				S_NORM: if (norm_end) begin
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_SHARE;
				S_SHARE: begin
					if (total_q[31:0] == '0) begin
						state_q <= S_FIN;
					end else begin
						dstart_q <= 1'b1;
						state_q  <= S_WSHARE;
					end
				end
				S_WSHARE: if (div_done) begin
					state_q <= S_FIN;
				end
				S_FIN: state_q <= S_OUT;
				S_OUT: if (result.ready) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (sample.valid) begin
				ut_q   <= sample.user_ticks;
				st_q   <= sample.system_ticks;
				ns_q   <= sample.runtime_ns;
				pu_q   <= sample.prev_user_time;
				ps_q   <= sample.prev_system_time;
				psum_q <= sample.prev_user_time + sample.prev_system_time;
			end
			S_START: begin
				dvd_q <= NS_PER_SEC;
				dvs_q <= {{(DW-RW){1'b0}}, hz};
			end
			S_WRATE: if (div_done) begin
				if (div_rem == '0) begin
					dvd_q <= ns_q;
					dvs_q <= div_quo;
				end else if (hz[8:0] == '0) begin
					dvd_q <= scaled >> 9;
					dvs_q <= NS_PER_512;
				end else begin
					dvd_q <= NS_X9 + {{(DW-RW+1){1'b0}}, hz[RW-1:1]};
					dvs_q <= {{(DW-RW){1'b0}}, hz};
				end
			end
			S_WDIVR: if (div_done) begin
				dvd_q <= (ns_q << 3) + ns_q;
				dvs_q <= div_quo;
			end
			S_WTICKS: if (div_done) begin
				rt_q <= div_quo;
			end
			S_CMP: begin
				// A zero user count gives everything to system time, a zero
				// system count everything to user time.
				if (ut_q == '0) begin
					shs_q <= rt_q;
					shu_q <= '0;
				end else begin
					shs_q <= '0;
					shu_q <= rt_q;
				end
				part_q  <= st_q;
				whole_q <= rt_q;
				total_q <= st_q + ut_q;
			end
			S_NORM: begin
				if (norm_end) begin
					part_q  <= p_sw;
					whole_q <= w_sw;
				end else if (total_q[63:32] == '0 && p_sw[63:31] == '0) begin
					part_q  <= p_sw << 1;
					whole_q <= w_sw >> 1;
				end else begin
					part_q  <= p_sw;
					whole_q <= w_sw >> 1;
					total_q <= total_q >> 1;
				end
			end
			S_MUL: prod_q <= part_q[31:0] * whole_q[31:0];
			S_SHARE: begin
				dvd_q <= prod_q;
				dvs_q <= {32'd0, total_q[31:0]};
				shs_q <= '0;
				shu_q <= rt_q;
			end
			S_WSHARE: if (div_done) begin
				shs_q <= div_quo;
				shu_q <= rt_q - div_quo;
			end
			S_FIN: begin
				if (shs_q > ps_q) begin
					ps_q <= shs_q;
				end
				if (shu_q > pu_q) begin
					pu_q <= shu_q;
				end
			end
			default: ;
		endcase
	end

	assign sample.ready       = (state_q == S_IDLE);
	assign result.valid       = (state_q == S_OUT);
	assign result.user_time   = pu_q;
	assign result.system_time = ps_q;

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready |-> !result.valid) else $error("input taken while result pending");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_WRATE || state_q == S_WDIVR || state_q == S_WTICKS ||
		state_q == S_WSHARE)) else $error("divider finished outside a wait state");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> !sample.ready) else $error("ready after accept");
`endif
endmodule
`default_nettype wire

@@ tb/tb_pkg.sv @@
// Shared item type for the CPU time split scaler testbench.
package tb_pkg;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0] user_ticks;
		logic [63:0] system_ticks;
		logic [63:0] runtime_ns;
		logic [63:0] prev_user_time;
		logic [63:0] prev_system_time;
	} sample_t;

	typedef struct packed {
		logic [63:0] user_time;
		logic [63:0] system_time;
	} times_t;
endpackage

@@ tb/testbench.sv @@
// Testbench for the CPU time split scaler: directed and random samples checked against a predictor.
module testbench;
	import cts_pkg::*;
	import tb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CFG_INDEX = 0;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [RW-1:0] cfg_wdata = '0;

	cts_sample_if sample();
	cts_result_if result();

	cpu_time_split_scaler u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.sample(sample.sink), .result(result.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [RW-1:0] rate_hz;
	times_t expected_times[$];
	int errors = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic logic [63:0] ns_to_ticks(input logic [63:0] ns);
		logic [63:0] hz;
		hz = {53'd0, rate_hz};
		if (hz == 0)
			hz = 1;
		if (NS_PER_SEC % hz == 0)
			return ns / (NS_PER_SEC / hz);
		if (hz % 512 == 0)
			return ((ns * hz) / 512) / NS_PER_512;
		return (ns * 64'd9) / ((NS_X9 + hz / 2) / hz);
	endfunction

	function automatic logic [63:0] system_share(input logic [63:0] part_in,
			input logic [63:0] whole_in, input logic [63:0] total_in);
		logic [63:0] part, whole, total, t;
		part = part_in;
		whole = whole_in;
		total = total_in;
		forever begin
			if (part > whole) begin
				t = part;
				part = whole;
				whole = t;
			end
			if (total[63:32] == 0) begin
				if (whole[63:32] == 0)
					break;
				if (part[63:31] == 0) begin
					part = part << 1;
					whole = whole >> 1;
					continue;
				end
			end
			whole = whole >> 1;
			total = total >> 1;
		end
		if (total[31:0] == 0)
			return 0;
		return ({32'd0, part[31:0]} * {32'd0, whole[31:0]}) / {32'd0, total[31:0]};
	endfunction

	function automatic times_t split_times(input sample_t s);
		times_t r;
		logic [63:0] ticks, sys_new, usr_new;
		ticks = ns_to_ticks(s.runtime_ns);
		r.user_time = s.prev_user_time;
		r.system_time = s.prev_system_time;
		if (s.prev_system_time + s.prev_user_time < ticks) begin
			if (s.user_ticks == 0) begin
				sys_new = ticks;
				usr_new = 0;
			end else if (s.system_ticks == 0) begin
				sys_new = 0;
				usr_new = ticks;
			end else begin
				sys_new = system_share(s.system_ticks, ticks,
					s.system_ticks + s.user_ticks);
				usr_new = ticks - sys_new;
			end
			if (sys_new > r.system_time)
				r.system_time = sys_new;
			if (usr_new > r.user_time)
				r.user_time = usr_new;
		end
		return r;
	endfunction

	initial begin
		sample.valid = 1'b0;
		sample.user_ticks = '0;
		sample.system_ticks = '0;
		sample.runtime_ns = '0;
		sample.prev_user_time = '0;
		sample.prev_system_time = '0;
	end

	// Receiver: random stalls, checked at the rising edge.
	always @(negedge clk)
		result.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		times_t want;
		if (sample.valid && sample.ready || result.valid && result.ready)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && result.valid && result.ready) begin
			if (expected_times.size() == 0) begin
				report_mismatch("unexpected result", result.user_time, 0);
			end else begin
				want = expected_times.pop_front();
				if (result.user_time !== want.user_time)
					report_mismatch("user_time", result.user_time, want.user_time);
				if (result.system_time !== want.system_time)
					report_mismatch("system_time", result.system_time, want.system_time);
			end
		end
	end

	always @(posedge clk)
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end

	task automatic send_sample(input sample_t s);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		sample.valid <= 1'b1;
		sample.user_ticks <= s.user_ticks;
		sample.system_ticks <= s.system_ticks;
		sample.runtime_ns <= s.runtime_ns;
		sample.prev_user_time <= s.prev_user_time;
		sample.prev_system_time <= s.prev_system_time;
		do
			@(posedge clk);
		while (!sample.ready);
		expected_times.push_back(split_times(s));
		@(negedge clk);
		sample.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (expected_times.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_rate(input logic [RW-1:0] hz);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= hz;
		@(negedge clk);
		cfg_we <= 1'b0;
		rate_hz = hz;
	endtask

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(5))
			0: v = 0;
			1: v = v >> $urandom_range(63);
			2: v = ~64'd0 - $urandom_range(3);
			default: ;
		endcase
		return v;
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		logic [63:0] base;
		s.user_ticks = rand64();
		s.system_ticks = rand64();
		s.runtime_ns = rand64();
		// Previous times mostly below the converted runtime so the split runs.
		base = ns_to_ticks(s.runtime_ns);
		if ($urandom_range(3) != 0) begin
			s.prev_user_time = base == 0 ? 0 : ({$urandom, $urandom} % base) >> 1;
			s.prev_system_time = base == 0 ? 0 : ({$urandom, $urandom} % base) >> 1;
		end else begin
			s.prev_user_time = rand64();
			s.prev_system_time = rand64();
		end
		return s;
	endfunction

	task automatic test_directed();
		logic [63:0] m;
		m = ~64'd0;
		send_sample('{0, 0, 0, 0, 0});
		send_sample('{m, m, m, m, m});
		send_sample('{0, 5, 64'd4000000000, 0, 0});
		send_sample('{7, 0, 64'd4000000000, 0, 0});
		send_sample('{3, 9, 64'd40000000000, 0, 0});
		send_sample('{m, 1, 64'd123456789012, 1, 2});
		send_sample('{m, 1, m, 0, 0});
		send_sample('{64'h8000000000000000, 64'h8000000000000000, m, 0, 0});
		send_sample('{1, m, m, 0, 0});
		send_sample('{5, 5, 64'd40000000000, 100, 0});
		send_sample('{5, 5, 64'd40000000000, 0, 100});
		send_sample('{5, 5, 64'd40000000000, 9, 1});
		send_sample('{5, 5, 64'd40000000000, m, 2});
		send_sample('{64'h0000000100000000, 64'h00000000ffffffff, m, 3, 4});
	endtask

	task automatic test_rates();
		logic [RW-1:0] rates[7] = '{0, 24, 512, 1024, 1200, 300, 2047};
		foreach (rates[i]) begin
			write_rate(rates[i]);
			repeat (6) send_sample(random_sample());
		end
	endtask

	task automatic test_random(input int count);
		logic [RW-1:0] hz;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 99) begin
				hz = $urandom_range(2) == 0 ? RW'($urandom_range(2047)) :
					RW'($urandom_range(1200, 24));
				write_rate(hz);
			end
			send_sample(random_sample());
		end
	endtask

	initial begin
		rate_hz = RATE_RESET;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 14;
		recv_stall_pct = 46;
		test_directed();
		test_rates();
		test_random(230);
		send_idle_pct = 46;
		recv_stall_pct = 14;
		test_random(230);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(240);
		write_rate(RATE_RESET);
		wait_idle();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
